>>> rtl/wpde_pkg.sv
package wpde_pkg;

  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned DUTY_W         = 8;
  localparam int unsigned DEG_W          = 6;
  localparam int unsigned TAN_W          = 17;  // unsigned Q1.16
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_EN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO = 4'd3;

  localparam logic [DEG_W-1:0]  BRIGHT_RST    = 6'd45;
  localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 8'd60;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 8'd30;

  // item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_LATCH = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [DUTY_W-1:0] duty_t;

  // tan(deg) in Q1.16; anything above 45 degrees saturates to 1.0
  function automatic logic [TAN_W-1:0] tan_q16(input logic [DEG_W-1:0] deg);
    logic [TAN_W-1:0] t;
    case (deg)
      6'd0:  t = 17'd0;      6'd1:  t = 17'd1144;   6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;   6'd4:  t = 17'd4583;   6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;   6'd7:  t = 17'd8047;   6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380;  6'd10: t = 17'd11556;  6'd11: t = 17'd12739;
      6'd12: t = 17'd13930;  6'd13: t = 17'd15130;  6'd14: t = 17'd16340;
      6'd15: t = 17'd17560;  6'd16: t = 17'd18792;  6'd17: t = 17'd20036;
      6'd18: t = 17'd21294;  6'd19: t = 17'd22566;  6'd20: t = 17'd23853;
      6'd21: t = 17'd25157;  6'd22: t = 17'd26478;  6'd23: t = 17'd27818;
      6'd24: t = 17'd29179;  6'd25: t = 17'd30560;  6'd26: t = 17'd31964;
      6'd27: t = 17'd33392;  6'd28: t = 17'd34846;  6'd29: t = 17'd36327;
      6'd30: t = 17'd37837;  6'd31: t = 17'd39378;  6'd32: t = 17'd40951;
      6'd33: t = 17'd42560;  6'd34: t = 17'd44205;  6'd35: t = 17'd45889;
      6'd36: t = 17'd47615;  6'd37: t = 17'd49385;  6'd38: t = 17'd51202;
      6'd39: t = 17'd53070;  6'd40: t = 17'd54991;  6'd41: t = 17'd56970;
      6'd42: t = 17'd59009;  6'd43: t = 17'd61113;  6'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/ws2812_pixel_duty_encoder_unit.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_mode, in_red, in_green, in_blue
// out_      output     out_valid / out_stall  out_duty, out_last
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel gives 24 results, an end-of-frame item RESET_SLOTS results, one per cycle while
// out_stall is low, from the bit serialiser; that serialiser sets the sustained rate.
// Input path: scaling multiply into a one-item holding register, then the serialiser.
// Reset (rst_n low, synchronous) empties all stages and restores the register defaults.
// A stalled output holds; the holding register takes the next item while one is sent.
module ws2812_pixel_duty_encoder_unit
  import wpde_pkg::*;
#(
  parameter int unsigned RESET_SLOTS = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  chan_t                 in_red,
  input  chan_t                 in_green,
  input  chan_t                 in_blue,

  output logic                  out_valid,
  input  logic                  out_stall,
  output duty_t                 out_duty,
  output logic                  out_last,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned MAX_SLOTS = (RESET_SLOTS > BITS_PER_PIXEL) ?
                                      RESET_SLOTS : BITS_PER_PIXEL;
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS);

  localparam logic [CNT_W-1:0] PIX_LAST = CNT_W'(BITS_PER_PIXEL - 1);
  localparam logic [CNT_W-1:0] GAP_LAST = CNT_W'(RESET_SLOTS - 1);

  // configuration
  logic             scale_en_r;
  logic [DEG_W-1:0] bright_r;
  duty_t            duty_one_r;
  duty_t            duty_zero_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_en_r  <= 1'b0;
      bright_r    <= BRIGHT_RST;
      duty_one_r  <= DUTY_ONE_RST;
      duty_zero_r <= DUTY_ZERO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE_EN:  scale_en_r  <= cfg_data[0];
        REG_BRIGHT:    bright_r    <= cfg_data[DEG_W-1:0];
        REG_DUTY_ONE:  duty_one_r  <= cfg_data;
        REG_DUTY_ZERO: duty_zero_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scaling
  logic [TAN_W-1:0] factor;
  chan_t            red_s, green_s, blue_s;

  assign factor = tan_q16(bright_r);

  wpde_scale u_scale_r (.scale_en(scale_en_r), .factor(factor), .chan_in(in_red),
                        .chan_out(red_s));
  wpde_scale u_scale_g (.scale_en(scale_en_r), .factor(factor), .chan_in(in_green),
                        .chan_out(green_s));
  wpde_scale u_scale_b (.scale_en(scale_en_r), .factor(factor), .chan_in(in_blue),
                        .chan_out(blue_s));

  // holding register
  logic                      hold_valid_r, hold_valid_nxt;
  logic                      hold_mode_r;
  logic [BITS_PER_PIXEL-1:0] hold_word_r;

  // serialiser
  logic                      ser_busy_r, ser_busy_nxt;
  logic                      ser_mode_r;
  logic [BITS_PER_PIXEL-1:0] ser_word_r;
  logic [CNT_W-1:0]          ser_cnt_r;

  // output register
  logic  out_valid_r, out_valid_nxt;
  duty_t out_duty_r;
  logic  out_last_r;

  logic in_xfer, out_free, emit, ser_done, ser_load;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = ser_busy_r && out_free;
  assign ser_done = emit && (ser_cnt_r == '0);
  assign ser_load = hold_valid_r && (!ser_busy_r || ser_done);
  assign in_stall = hold_valid_r && !ser_load;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (ser_load) hold_valid_nxt = 1'b0;
    if (in_xfer)  hold_valid_nxt = 1'b1;

    ser_busy_nxt = ser_busy_r;
    if (ser_done) ser_busy_nxt = 1'b0;
    if (ser_load) ser_busy_nxt = 1'b1;

    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (emit)                      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      ser_busy_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      ser_busy_r   <= ser_busy_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_mode_r <= in_mode;
      hold_word_r <= {green_s, red_s, blue_s};
    end
    if (ser_load) begin
      ser_mode_r <= hold_mode_r;
      ser_word_r <= hold_word_r;
      ser_cnt_r  <= (hold_mode_r == MODE_LATCH) ? GAP_LAST : PIX_LAST;
    end else if (emit) begin
      ser_word_r <= {ser_word_r[BITS_PER_PIXEL-2:0], 1'b0};
      ser_cnt_r  <= ser_cnt_r - 1'b1;
    end
    if (emit) begin
      if (ser_mode_r == MODE_LATCH) out_duty_r <= '0;
      else out_duty_r <= ser_word_r[BITS_PER_PIXEL-1] ? duty_one_r : duty_zero_r;
      out_last_r <= (ser_cnt_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign out_last  = out_last_r;

  // checks
  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_valid_r)
    else $error("input stalled with an empty holding register");

  a_ser_keeps_going: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (ser_cnt_r != '0) |=> ser_busy_r)
    else $error("serialiser stopped before its final slot");

  a_gap_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (ser_mode_r == MODE_LATCH) |=> (out_duty_r == '0))
    else $error("non-zero duty in latch gap");

  a_emit_makes_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted slot not presented");

endmodule

>>> rtl/wpde_scale.sv
module wpde_scale
  import wpde_pkg::*;
(
  input  logic             scale_en,
  input  logic [TAN_W-1:0] factor,
  input  chan_t            chan_in,
  output chan_t            chan_out
);

  logic [CHAN_W+TAN_W-1:0] prod;

  // truncating multiply; factor never exceeds 1.0 so the result fits a byte
  assign prod     = {{TAN_W{1'b0}}, chan_in} * {{CHAN_W{1'b0}}, factor};
  assign chan_out = scale_en ? prod[CHAN_W+15:16] : chan_in;

endmodule

>>> tb/testbench.sv
module testbench;
  import wpde_pkg::*;

  localparam int unsigned LATCH_SLOTS    = 50;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PRESSURE_HOLD  = 400;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 28;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  // expected duty stream of the encoder, one entry per bit slot
  class duty_stream_board;
    typedef struct {
      duty_t duty;
      logic  is_last;
    } slot_t;

    slot_t            expected_slots[$];
    logic             scale_en;
    logic [DEG_W-1:0] bright_deg;
    duty_t            duty_one;
    duty_t            duty_zero;
    int unsigned      tan_lut [46];
    int               errors;
    int               slots_seen;
    int               pixels;
    int               frame_ends;

    function new();
      // tan(k deg) in Q1.16
      tan_lut = '{
            0,  1144,  2289,  3435,  4583,  5734,  6888,  8047,
         9210, 10380, 11556, 12739, 13930, 15130, 16340, 17560,
        18792, 20036, 21294, 22566, 23853, 25157, 26478, 27818,
        29179, 30560, 31964, 33392, 34846, 36327, 37837, 39378,
        40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
        54991, 56970, 59009, 61113, 63287, 65536};
      scale_en   = 1'b0;
      bright_deg = BRIGHT_RST;
      duty_one   = DUTY_ONE_RST;
      duty_zero  = DUTY_ZERO_RST;
      errors     = 0;
      slots_seen = 0;
      pixels     = 0;
      frame_ends = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SCALE_EN:  scale_en = val[0];
        REG_BRIGHT:    bright_deg = val[DEG_W-1:0];
        REG_DUTY_ONE:  duty_one = val;
        REG_DUTY_ZERO: duty_zero = val;
        default: ;
      endcase
    endfunction

    function chan_t scaled(chan_t ch);
      int unsigned deg = (bright_deg > 45) ? 45 : bright_deg;
      if (!scale_en) return ch;
      return chan_t'((ch * tan_lut[deg]) >> 16);
    endfunction

    function void note_item(logic mode, chan_t r, chan_t g, chan_t b);
      logic [BITS_PER_PIXEL-1:0] word;
      slot_t s;
      if (mode == MODE_LATCH) begin
        frame_ends++;
        for (int k = 0; k < LATCH_SLOTS; k++) begin
          s.duty    = '0;
          s.is_last = (k == LATCH_SLOTS - 1);
          expected_slots.push_back(s);
        end
      end else begin
        pixels++;
        word = {scaled(g), scaled(r), scaled(b)};
        for (int k = 0; k < BITS_PER_PIXEL; k++) begin
          s.duty    = word[BITS_PER_PIXEL-1-k] ? duty_one : duty_zero;
          s.is_last = (k == BITS_PER_PIXEL - 1);
          expected_slots.push_back(s);
        end
      end
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR: slot %0d: %s", slots_seen, msg);
      errors++;
    endtask

    task check_slot(duty_t duty, logic is_last);
      slot_t s;
      slots_seen++;
      if (expected_slots.size() == 0) begin
        report($sformatf("unexpected transfer duty=%0d last=%0b", duty, is_last));
        return;
      end
      s = expected_slots.pop_front();
      if (duty !== s.duty)
        report($sformatf("duty %0d, expected %0d", duty, s.duty));
      if (is_last !== s.is_last)
        report($sformatf("last %0b, expected %0b", is_last, s.is_last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_mode;
  chan_t                 in_red;
  chan_t                 in_green;
  chan_t                 in_blue;
  logic                  out_valid;
  logic                  out_stall;
  duty_t                 out_duty;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  duty_stream_board board = new();

  bit rx_quiet  = 1'b0;
  bit tx_quiet  = 1'b0;
  bit long_hold = 1'b0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  ws2812_pixel_duty_encoder_unit #(
    .RESET_SLOTS(LATCH_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_duty  (out_duty),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic chan_t pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic mode, input chan_t r, input chan_t g, input chan_t b);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_item(mode, r, g, b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.set_reg(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every expected slot has been seen
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic directed_run();
    // register defaults: scaling off
    send_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(MODE_PIXEL, 8'hAA, 8'h55, 8'h0F);
    send_item(MODE_LATCH, 8'h12, 8'h34, 8'h56);
    send_item(MODE_PIXEL, 8'h01, 8'h80, 8'hFE);
    settle();
    write_reg(REG_SCALE_EN, 8'hFF);
    write_reg(REG_BRIGHT, 8'h00);
    send_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(MODE_LATCH, 8'hFF, 8'hFF, 8'hFF);
    settle();
    write_reg(REG_BRIGHT, 8'd1);
    send_item(MODE_PIXEL, 8'hFF, 8'h80, 8'hC8);
    settle();
    write_reg(REG_BRIGHT, 8'd44);
    write_reg(REG_DUTY_ONE, 8'hFF);
    write_reg(REG_DUTY_ZERO, 8'h00);
    send_item(MODE_PIXEL, 8'hFF, 8'hFE, 8'h03);
    send_item(MODE_PIXEL, 8'h01, 8'h02, 8'h7F);
    settle();
    // upper data bits dropped: angle 63 saturates to 45
    write_reg(REG_BRIGHT, 8'hFF);
    write_reg(REG_DUTY_ONE, 8'h00);
    write_reg(REG_DUTY_ZERO, 8'hFF);
    send_item(MODE_PIXEL, 8'hC8, 8'h07, 8'hFF);
    settle();
    write_reg(REG_BRIGHT, 8'd46);
    write_reg(REG_UNUSED_LO, 8'h00);
    write_reg(REG_UNUSED_HI, 8'hFF);
    send_item(MODE_PIXEL, 8'h64, 8'h25, 8'hFF);
    settle();
    write_reg(REG_BRIGHT, 8'd45);
    send_item(MODE_PIXEL, 8'hFF, 8'h00, 8'hAA);
    settle();
    // scaling off must ignore a zero angle
    write_reg(REG_SCALE_EN, 8'h00);
    write_reg(REG_BRIGHT, 8'd0);
    send_item(MODE_PIXEL, 8'h63, 8'hC8, 8'h1F);
    send_item(MODE_LATCH, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(REG_BRIGHT, 8'd23);
    write_reg(REG_SCALE_EN, 8'h01);
    send_item(MODE_PIXEL, 8'hFF, 8'h64, 8'h32);
    settle();
  endtask

  task automatic random_phase(input int ph);
    int gap;
    logic mode;
    write_reg(REG_SCALE_EN, 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 3))
      0: write_reg(REG_BRIGHT, 8'd0);
      1: write_reg(REG_BRIGHT, 8'd45);
      2: write_reg(REG_BRIGHT, 8'($urandom_range(46, 63)));
      default: write_reg(REG_BRIGHT, 8'($urandom_range(0, 255)));
    endcase
    write_reg(REG_DUTY_ONE, pick_byte());
    write_reg(REG_DUTY_ZERO, pick_byte());
    write_reg(4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 8'($urandom_range(0, 255)));
    if (ph == 2) begin
      // sink holds off while the source keeps pushing
      tx_quiet  = 1'b1;
      long_hold = 1'b1;
    end else if (ph == 4) begin
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      mode = ($urandom_range(0, 7) == 0) ? MODE_LATCH : MODE_PIXEL;
      send_item(mode, pick_byte(), pick_byte(), pick_byte());
      gap = pick_gap();
      if (!tx_quiet && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    settle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin : stimulus
    in_valid  <= 1'b0;
    in_mode   <= MODE_PIXEL;
    in_red    <= '0;
    in_green  <= '0;
    in_blue   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SCALE_EN;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_run();
    for (int ph = 0; ph < PHASES; ph++) random_phase(ph);
    settle();
    repeat (LATCH_SLOTS) @(posedge clk);
    $display("covered %0d pixels and %0d frame ends, %0d slot transfers checked",
             board.pixels, board.frame_ends, board.slots_seen);
    $display("%0d register writes, brightness angles 0..63, duty extremes, stalls and gaps",
             cfg_writes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ws2812_pixel_duty_encoder_unit: match");
    end else begin
      $display("ws2812_pixel_duty_encoder_unit: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    int stall_len;
    int run_len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        stall_len = PRESSURE_HOLD;
      end else if (rx_quiet) begin
        stall_len = 0;
      end else begin
        stall_len = pick_gap();
      end
      run_len = $urandom_range(1, 40);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_slot(out_duty, out_last);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d slots outstanding",
               idle_cycles, board.pending());
      $display("ws2812_pixel_duty_encoder_unit: mismatch");
      $finish;
    end
  end

endmodule
